// File: design/ipo_pkg.sv
// Shared types and constants for the impact parameter pipeline.
`timescale 1ns / 1ps

package ipo_pkg;

    // Quotient bits kept by the divider; anything wider saturates the root
    localparam int QUO_WIDTH  = 64;
    // Width of the square root result
    localparam int ROOT_WIDTH = 32;
    // Extra fractional bits applied to |r x p|^2 before the divide
    localparam int NUM_SHIFT  = 16;

    // Sideband that travels with each word through the divider and root stages
    typedef struct packed {
        logic valid;
        logic zero;
        logic sat;
    } t_side;

endpackage

// File: design/ipo_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
`timescale 1ns / 1ps

module ipo_div #(
    parameter int NUM_WIDTH = 80,
    parameter int DEN_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ce,
    input  ipo_pkg::t_side                 i_side,
    input  logic [NUM_WIDTH-1:0]           i_num,
    input  logic [DEN_WIDTH-1:0]           i_den,
    output ipo_pkg::t_side                 o_side,
    output logic [ipo_pkg::QUO_WIDTH-1:0]  o_quo
);

    localparam int QW   = ipo_pkg::QUO_WIDTH;
    localparam int HI_W = NUM_WIDTH - QW;

    ipo_pkg::t_side         r_sd  [0:QW];
    logic [DEN_WIDTH-1:0]   r_rem [0:QW];
    logic [QW-1:0]          r_low [0:QW];
    logic [DEN_WIDTH-1:0]   r_den [0:QW];

    // Overflow check: quotient of 2^64 or more saturates the root
    logic [HI_W-1:0] w_hi;
    logic            w_ovf;

    always_comb begin
        w_hi  = i_num[NUM_WIDTH-1:QW];
        w_ovf = (w_hi >= HI_W'(i_den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd[0] <= '0;
        end else if (i_ce) begin
            r_sd[0] <= '{valid: i_side.valid, zero: i_side.zero, sat: w_ovf};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= w_ovf ? '0 : w_hi[DEN_WIDTH-1:0];
            r_low[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
        end
    end

    // One shift-compare-subtract per stage; quotient bits shift into r_low
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DEN_WIDTH:0] w_trial;
        logic [DEN_WIDTH:0] w_diff;
        logic               w_ge;

        always_comb begin
            w_trial = {r_rem[k], r_low[k][QW-1]};
            w_diff  = w_trial - {1'b0, r_den[k]};
            w_ge    = (w_trial >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[k+1] <= '0;
            end else if (i_ce) begin
                r_sd[k+1] <= r_sd[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k+1] <= w_ge ? w_diff[DEN_WIDTH-1:0] : w_trial[DEN_WIDTH-1:0];
                r_low[k+1] <= {r_low[k][QW-2:0], w_ge};
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_side = r_sd[QW];
    assign o_quo  = r_low[QW];

endmodule

// File: design/ipo_sqrt.sv
// Pipelined integer square root of the 64-bit quotient, one root bit per stage.
`timescale 1ns / 1ps

module ipo_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ce,
    input  ipo_pkg::t_side                  i_side,
    input  logic [ipo_pkg::QUO_WIDTH-1:0]   i_rad,
    output ipo_pkg::t_side                  o_side,
    output logic [ipo_pkg::ROOT_WIDTH-1:0]  o_root
);

    localparam int QW = ipo_pkg::QUO_WIDTH;
    localparam int RW = ipo_pkg::ROOT_WIDTH;

    ipo_pkg::t_side  r_sd   [1:RW];
    logic [RW+1:0]   r_rem  [1:RW];
    logic [RW-1:0]   r_root [1:RW];
    logic [QW-1:0]   r_rad  [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        ipo_pkg::t_side w_sd;
        logic [RW+1:0]  w_rem;
        logic [RW-1:0]  w_root;
        logic [QW-1:0]  w_rad;
        logic [RW+1:0]  w_t;
        logic [RW+1:0]  w_trial;
        logic           w_ge;

        // First stage takes the divider output, later ones the previous stage
        if (k == 0) begin : g_first
            assign w_sd   = i_side;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
        end else begin : g_next
            assign w_sd   = r_sd[k];
            assign w_rem  = r_rem[k];
            assign w_root = r_root[k];
            assign w_rad  = r_rad[k];
        end

        // Bring down two radicand bits and try root*4+1
        always_comb begin
            w_t     = {w_rem[RW-1:0], w_rad[QW-1:QW-2]};
            w_trial = {w_root, 2'b01};
            w_ge    = (w_t >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[k+1] <= '0;
            end else if (i_ce) begin
                r_sd[k+1] <= w_sd;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k+1]  <= w_ge ? (w_t - w_trial) : w_t;
                r_root[k+1] <= {w_root[RW-2:0], w_ge};
                r_rad[k+1]  <= {w_rad[QW-3:0], 2'b00};
            end
        end
    end

    assign o_side = r_sd[RW];
    assign o_root = r_root[RW];

endmodule

// File: design/impact_parameter_from_origin.sv
// Top level: distance from the origin to a straight track, fully pipelined.
`timescale 1ns / 1ps

// Takes one particle word per clock (vertex r and momentum p, signed
// COORD_WIDTH-bit components) and returns floor(sqrt(|r x p|^2 * 2^16 / |p|^2))
// as a 32-bit distance with 8 fractional bits, saturating at 2^32-1. A zero
// momentum gives distance 0 with the tuser flag set. Throughput is one word
// per clock while the output buffer is not full; the path is 6 arithmetic
// stages, 65 divider stages (overflow check plus one quotient bit each) and
// 32 square root stages, 103 register stages, then the two-word output
// buffer. The whole pipeline advances together and holds only while that
// output buffer is full.
module impact_parameter_from_origin #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // vertex_x, vertex_y, vertex_z, momentum_x, momentum_y, momentum_z
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]        i_s_tdata,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // impact_distance
    output logic [ipo_pkg::ROOT_WIDTH-1:0]            o_m_tdata,
    // zero_momentum
    output logic                                      o_m_tuser,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W;           // coordinate product
    localparam int SQ = 4 * W;           // square of one cross component
    localparam int NW = SQ + 2;          // |r x p|^2
    localparam int DW = 2 * W;           // |p|^2
    localparam int QW = ipo_pkg::QUO_WIDTH;
    localparam int RW = ipo_pkg::ROOT_WIDTH;
    localparam int XW = (NW + ipo_pkg::NUM_SHIFT > QW + DW) ?
                        (NW + ipo_pkg::NUM_SHIFT) : (QW + DW);

    logic w_ce;
    logic w_push;
    logic w_pop;

    // Stage A: input capture
    logic                r_a_valid;
    logic signed [W-1:0] r_a_crd [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ce) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 6; i++) begin
                r_a_crd[i] <= i_s_tdata[i*W +: W];
            end
        end
    end

    // Stage B: six coordinate products, momentum magnitudes, zero test
    logic                 r_b_valid;
    logic                 r_b_zero;
    logic signed [PW-1:0] r_b_prod [0:5];
    logic [W-1:0]         r_b_pabs [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ce) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            // pairs: (ry*pz, rz*py), (rz*px, rx*pz), (rx*py, ry*px)
            r_b_prod[0] <= r_a_crd[1] * r_a_crd[5];
            r_b_prod[1] <= r_a_crd[2] * r_a_crd[4];
            r_b_prod[2] <= r_a_crd[2] * r_a_crd[3];
            r_b_prod[3] <= r_a_crd[0] * r_a_crd[5];
            r_b_prod[4] <= r_a_crd[0] * r_a_crd[4];
            r_b_prod[5] <= r_a_crd[1] * r_a_crd[3];
            for (int i = 0; i < 3; i++) begin
                r_b_pabs[i] <= r_a_crd[i+3][W-1] ? (~r_a_crd[i+3] + 1'b1) : r_a_crd[i+3];
            end
            r_b_zero <= (r_a_crd[3] == '0) && (r_a_crd[4] == '0) && (r_a_crd[5] == '0);
        end
    end

    // Stage C: magnitudes of the cross product components
    logic          r_c_valid;
    logic          r_c_zero;
    logic [PW-1:0] r_c_mag  [0:2];
    logic [W-1:0]  r_c_pabs [0:2];
    logic [PW:0]   w_c_diff [0:2];
    logic [PW:0]   w_c_neg  [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c_diff[i] = {r_b_prod[2*i][PW-1], r_b_prod[2*i]}
                        - {r_b_prod[2*i+1][PW-1], r_b_prod[2*i+1]};
            w_c_neg[i]  = ~w_c_diff[i] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_ce) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_c_mag[i]  <= w_c_diff[i][PW] ? w_c_neg[i][PW-1:0] : w_c_diff[i][PW-1:0];
                r_c_pabs[i] <= r_b_pabs[i];
            end
            r_c_zero <= r_b_zero;
        end
    end

    // Stage D: partial products of the squares, split at W bits
    logic          r_d_valid;
    logic          r_d_zero;
    logic [PW-1:0] r_d_hh  [0:2];
    logic [PW-1:0] r_d_hl  [0:2];
    logic [PW-1:0] r_d_ll  [0:2];
    logic [PW-1:0] r_d_psq [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_ce) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_d_hh[i]  <= r_c_mag[i][PW-1:W] * r_c_mag[i][PW-1:W];
                r_d_hl[i]  <= r_c_mag[i][PW-1:W] * r_c_mag[i][W-1:0];
                r_d_ll[i]  <= r_c_mag[i][W-1:0] * r_c_mag[i][W-1:0];
                r_d_psq[i] <= r_c_pabs[i] * r_c_pabs[i];
            end
            r_d_zero <= r_c_zero;
        end
    end

    // Stage E: full squares and |p|^2
    logic          r_e_valid;
    logic          r_e_zero;
    logic [SQ-1:0] r_e_sq [0:2];
    logic [DW-1:0] r_e_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_ce) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_e_sq[i] <= (SQ'(r_d_hh[i]) << PW) + (SQ'(r_d_hl[i]) << (W + 1))
                           + SQ'(r_d_ll[i]);
            end
            r_e_den  <= DW'(r_d_psq[0]) + DW'(r_d_psq[1]) + DW'(r_d_psq[2]);
            r_e_zero <= r_d_zero;
        end
    end

    // Stage F: |r x p|^2
    logic          r_f_valid;
    logic          r_f_zero;
    logic [NW-1:0] r_f_num;
    logic [DW-1:0] r_f_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_ce) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_f_num  <= NW'(r_e_sq[0]) + NW'(r_e_sq[1]) + NW'(r_e_sq[2]);
            r_f_den  <= r_e_den;
            r_f_zero <= r_e_zero;
        end
    end

    // Divide, then square root of the quotient
    ipo_pkg::t_side w_f_side;
    ipo_pkg::t_side w_q_side;
    ipo_pkg::t_side w_r_side;
    logic [XW-1:0]  w_num_ext;
    logic [QW-1:0]  w_quo;
    logic [RW-1:0]  w_root;
    logic [RW-1:0]  w_dist;

    assign w_f_side  = '{valid: r_f_valid, zero: r_f_zero, sat: 1'b0};
    assign w_num_ext = XW'(r_f_num) << ipo_pkg::NUM_SHIFT;

    ipo_div #(
        .NUM_WIDTH (XW),
        .DEN_WIDTH (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_side  (w_f_side),
        .i_num   (w_num_ext),
        .i_den   (r_f_den),
        .o_side  (w_q_side),
        .o_quo   (w_quo)
    );

    ipo_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_side  (w_q_side),
        .i_rad   (w_quo),
        .o_side  (w_r_side),
        .o_root  (w_root)
    );

    always_comb begin
        priority if (w_r_side.zero) begin
            w_dist = '0;
        end else if (w_r_side.sat) begin
            w_dist = '1;
        end else begin
            w_dist = w_root;
        end
    end

    // Two-word output buffer; pipeline advances unless it is full
    logic [1:0]    r_cnt;
    logic [RW-1:0] r_q_dist [0:1];
    logic          r_q_zero [0:1];
    logic          w_wr_head;
    logic          w_wr_tail;

    assign w_ce      = (r_cnt != 2'd2);
    assign w_push    = w_ce && w_r_side.valid;
    assign w_pop     = o_m_tvalid && i_m_tready;
    assign w_wr_head = w_push && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop));
    assign w_wr_tail = w_push && (r_cnt == 2'd1) && !w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_head) begin
            r_q_dist[0] <= w_dist;
            r_q_zero[0] <= w_r_side.zero;
        end else if (w_pop) begin
            r_q_dist[0] <= r_q_dist[1];
            r_q_zero[0] <= r_q_zero[1];
        end
        if (w_wr_tail) begin
            r_q_dist[1] <= w_dist;
            r_q_zero[1] <= w_r_side.zero;
        end
    end

    assign o_s_tready = w_ce;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_q_dist[0];
    assign o_m_tuser  = r_q_zero[0];

    // Zero momentum always reports distance zero
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("zero momentum word with nonzero distance");

    // Full buffer stalls the input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_s_tready)
        else $error("input ready while output buffer full");

    // Full buffer stays full until a word leaves
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == 2'd2) && !w_pop) |=> (r_cnt == 2'd2))
        else $error("output buffer count changed without a pop");

    // An accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_a_valid)
        else $error("accepted word lost at pipeline entry");

endmodule

// File: tb/ipo_checker.sv
// Checker for the impact parameter block: predicts each result and compares it.
`timescale 1ns / 1ps

module ipo_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // vertex_x, vertex_y, vertex_z, momentum_x, momentum_y, momentum_z
    input  logic [143:0] i_s_tdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // impact_distance
    input  logic [31:0]  i_m_tdata,
    // zero_momentum
    input  logic         i_m_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [31:0] distance;
        logic        zero_mom;
    } t_dist;

    t_dist dist_queue[$];

    // |a*b - c*d|, exact for 24-bit operands
    function automatic logic [63:0] cross_mag(input logic signed [23:0] a, b, c, d);
        logic signed [63:0] diff;
        diff = 64'(a) * 64'(b) - 64'(c) * 64'(d);
        return (diff < 0) ? 64'(-diff) : 64'(diff);
    endfunction

    function automatic logic [191:0] sq(input logic [63:0] m);
        logic [191:0] w;
        w = {128'b0, m};
        return w * w;
    endfunction

    // Floor of the distance from the origin, with 8 fractional bits
    function automatic t_dist impact_of(input logic [143:0] word);
        logic signed [23:0] rx, ry, rz, px, py, pz;
        logic [191:0] num, den, trial;
        logic [31:0]  q, cand;
        t_dist        res;
        rx = word[23:0];    ry = word[47:24];   rz = word[71:48];
        px = word[95:72];   py = word[119:96];  pz = word[143:120];
        res = '0;
        if (px == 0 && py == 0 && pz == 0) begin
            res.zero_mom = 1'b1;
            return res;
        end
        num = sq(cross_mag(ry, pz, rz, py)) + sq(cross_mag(rz, px, rx, pz))
            + sq(cross_mag(rx, py, ry, px));
        num = num << 16;
        den = sq(64'(px < 0 ? -64'(px) : 64'(px))) + sq(64'(py < 0 ? -64'(py) : 64'(py)))
            + sq(64'(pz < 0 ? -64'(pz) : 64'(pz)));
        // bitwise root, greedy from the top bit
        q = '0;
        for (int b = 31; b >= 0; b--) begin
            cand  = q | (32'd1 << b);
            trial = {160'b0, cand} * {160'b0, cand} * den;
            if (trial <= num) q = cand;
        end
        res.distance = q;
        return res;
    endfunction

    assign o_pending = dist_queue.size();

    always @(posedge i_clk) begin
        t_dist want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            // output word first, so a same-edge input is never matched early
            if (i_m_tvalid && i_m_tready) begin
                if (dist_queue.size() == 0) begin
                    $error("result word with nothing expected: impact_distance %0d",
                           i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = dist_queue.pop_front();
                    if (i_m_tdata !== want.distance || i_m_tuser !== want.zero_mom)
                        o_fail_count <= o_fail_count + 1;
                    if (i_m_tdata !== want.distance)
                        $error("impact_distance: expected %0d, actual %0d",
                               want.distance, i_m_tdata);
                    if (i_m_tuser !== want.zero_mom)
                        $error("zero_momentum: expected %0d, actual %0d",
                               want.zero_mom, i_m_tuser);
                end
            end
            if (i_s_tvalid && i_s_tready)
                dist_queue.push_back(impact_of(i_s_tdata));
        end
    end

endmodule

// File: tb/tb.sv
// Testbench top: stimulus, idling and verdict for the impact parameter block.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [23:0] C_MIN = 24'h800000;
    localparam logic [23:0] C_MAX = 24'h7FFFFF;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [143:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    int           fail_count;
    int           pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           cycles = 0;

    always #6 i_clk = ~i_clk;

    impact_parameter_from_origin uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready)
    );

    ipo_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready), .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls at random
    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one particle word; valid stays high across back-to-back words
    task automatic send_particle(input logic [23:0] rx, ry, rz, px, py, pz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tdata  <= {pz, py, px, rz, ry, rx};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [23:0] rand_coord(input int kind);
        case (kind)
            0: return 24'($urandom());
            1: return 24'($urandom_range(511) - 256);
            default: begin
                case ($urandom_range(4))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return 24'd0;
                    3: return 24'hFFFFFF;
                    default: return 24'd1;
                endcase
            end
        endcase
    endfunction

    task automatic random_particle();
        logic signed [23:0] px, py, pz;
        int sel, k;
        sel = $urandom_range(99);
        if (sel < 8) begin
            // zero momentum
            send_particle(rand_coord(0), rand_coord(0), rand_coord(0), '0, '0, '0);
        end else if (sel < 20) begin
            // vertex on the track line, small offset
            px = 24'($urandom_range(8191)) - 24'd4096;
            py = 24'($urandom_range(8191)) - 24'd4096;
            pz = 24'($urandom_range(8191)) - 24'd4096;
            k  = int'($urandom_range(2000)) - 1000;
            send_particle(24'(px * k + int'($urandom_range(2)) - 1), 24'(py * k),
                          24'(pz * k), px, py, pz);
        end else begin
            send_particle(rand_coord($urandom_range(2)), rand_coord($urandom_range(2)),
                          rand_coord($urandom_range(2)), rand_coord($urandom_range(2)),
                          rand_coord($urandom_range(2)), rand_coord($urandom_range(2)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero momentum, axis cases, parallel vertex
        send_particle('0, '0, '0, '0, '0, '0);
        send_particle(C_MAX, C_MIN, C_MAX, '0, '0, '0);
        send_particle(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        send_particle(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        send_particle(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
        send_particle(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN);
        send_particle(C_MAX, C_MAX, C_MAX, 24'd1, '0, '0);
        send_particle(C_MIN, C_MIN, C_MIN, '0, 24'd1, '0);
        send_particle(C_MIN, C_MAX, C_MIN, '0, '0, 24'hFFFFFF);
        send_particle(C_MIN, C_MAX, '0, '0, '0, C_MIN);
        send_particle(24'd256, '0, '0, '0, 24'd1, '0);
        send_particle(24'd256, '0, '0, 24'd5, '0, '0);
        send_particle(24'd1, 24'd1, 24'd1, C_MAX, 24'd1, C_MIN);
        send_particle(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd1, 24'd1);
        send_particle(C_MAX, '0, '0, '0, C_MAX, '0);
        send_particle(C_MIN, '0, '0, '0, '0, C_MIN);

        // random, three idling phases
        send_idle_pct = 23; recv_stall_pct = 72;
        repeat (330) random_particle();
        send_idle_pct = 72; recv_stall_pct = 23;
        repeat (330) random_particle();
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (340) random_particle();
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
